// ----- rtl/cbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_pkg: shared types and constants of the circle/box push-out block
// Fixed-point widths, beat structs, register indexes and coordinate saturation.
// ----------------------------------------------------------------------------
package cbp_pkg;

  localparam int CoordWidth  = 24;
  localparam int SpanWidth   = CoordWidth - 1;
  localparam int RadiusWidth = 16;
  localparam int R2Width     = RadiusWidth + 1;
  localparam int CfgIdxWidth = 8;

  // offsets past the far limit never overlap, so 19 signed bits carry the rest
  localparam int OffWidth    = 19;
  localparam int DsqWidth    = 34;
  localparam int RootWidth   = 29;
  localparam int RadWidth    = 2 * RootWidth;
  localparam int OvlWidth    = 29;
  localparam int ProdWidth   = OffWidth + OvlWidth + 1;
  localparam int MagWidth    = 48;
  localparam int NumWidth    = MagWidth + 1;
  localparam int DenWidth    = RootWidth + 1;
  localparam int QuoWidth    = 18;
  localparam int WideWidth   = CoordWidth + QuoWidth;

  localparam int MidDepth    = 4;
  localparam int OutDepth    = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgCenterX  = 8'd0,
    CfgCenterZ  = 8'd1,
    CfgBoxWidth = 8'd2,
    CfgBoxDepth = 8'd3
  } cfg_idx_e;

  typedef logic signed [WideWidth-1:0] wide_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pos_x;
    logic signed [CoordWidth-1:0] pos_z;
    logic [RadiusWidth-1:0]       radius;
  } in_item_t;

  typedef struct packed {
    logic                         hit;
    logic signed [CoordWidth-1:0] new_x;
    logic signed [CoordWidth-1:0] new_z;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] center_x;
    logic signed [CoordWidth-1:0] center_z;
    logic [SpanWidth-1:0]         box_width;
    logic [SpanWidth-1:0]         box_depth;
  } box_cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic                         push;
    logic                         hit;
    logic signed [CoordWidth-1:0] base_x;
    logic signed [CoordWidth-1:0] base_z;
    logic signed [OffWidth-1:0]   dx;
    logic signed [OffWidth-1:0]   dz;
    logic [DsqWidth-1:0]          dsq;
    logic [R2Width-1:0]           r2;
  } mid_item_t;

  function automatic logic signed [CoordWidth-1:0] sat_coord(input wide_t v);
    logic in_range;
    in_range = (v[WideWidth-1:CoordWidth-1] == {(WideWidth-CoordWidth+1){v[WideWidth-1]}});
    if (in_range) return v[CoordWidth-1:0];
    else if (v[WideWidth-1]) return {1'b1, {(CoordWidth-1){1'b0}}};
    else return {1'b0, {(CoordWidth-1){1'b1}}};
  endfunction

endpackage

// ----- rtl/cbp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_queue: small register queue
// First-in first-out buffer with ready/valid on both sides; DEPTH is a power of two.
// ----------------------------------------------------------------------------
module cbp_queue import cbp_pkg::*; #(
  parameter int  DEPTH  = MidDepth,
  parameter type item_t = mid_item_t
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_item_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output item_t rd_item_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem_q [DEPTH];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           wr, rd;

  assign wr_ready_o = (cnt_q != CW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_ready_i && rd_valid_o;
  assign rd_item_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) cnt_d = cnt_q + CW'(1);
    else if (rd && !wr) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + PW'(1);
      if (rd) rptr_q <= rptr_q + PW'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= wr_item_i;
  end

endmodule

// ----- rtl/cbp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_front: clamp, overlap test and inside-box snap
// Two stages: offsets and face distances, then squares and face choice.
// ----------------------------------------------------------------------------
module cbp_front import cbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  input  box_cfg_t  cfg_i,
  output logic      out_valid_o,
  output mid_item_t out_item_o
);

  localparam int EW      = CoordWidth + 5;
  localparam int SqWidth = 2 * OffWidth;

  typedef logic signed [EW-1:0] ext_t;

  localparam ext_t FarLim = ext_t'(2 ** (OffWidth - 1));

  typedef struct packed {
    logic                         near;
    logic signed [OffWidth-1:0]   dx;
    logic signed [OffWidth-1:0]   dz;
    logic signed [CoordWidth-1:0] px;
    logic signed [CoordWidth-1:0] pz;
    logic [R2Width-1:0]           r2;
    ext_t                         fl, fr, fb, ff;
    ext_t                         pl, pr, pb, pf;
  } f1_t;

  typedef struct packed {
    logic                         near;
    logic [SqWidth-1:0]           dsq;
    logic [DsqWidth-1:0]          rsq;
    logic signed [OffWidth-1:0]   dx;
    logic signed [OffWidth-1:0]   dz;
    logic signed [CoordWidth-1:0] px;
    logic signed [CoordWidth-1:0] pz;
    logic [R2Width-1:0]           r2;
    logic signed [CoordWidth-1:0] snap_x;
    logic signed [CoordWidth-1:0] snap_z;
  } f2_t;

  function automatic ext_t sx(input logic signed [CoordWidth-1:0] v);
    return {{(EW-CoordWidth){v[CoordWidth-1]}}, v};
  endfunction

  function automatic ext_t absv(input ext_t v);
    return v[EW-1] ? -v : v;
  endfunction

  f1_t  f1_d, f1_q;
  f2_t  f2_d, f2_q;
  logic f1_v_q, f2_v_q;

  // stage 1: box bounds at half-LSB scale, clamp, faces grown by the radius
  always_comb begin
    ext_t px2, pz2, minx, maxx, minz, maxz, r2e, clx, clz, dxw, dzw;
    px2  = sx(in_item_i.pos_x) <<< 1;
    pz2  = sx(in_item_i.pos_z) <<< 1;
    minx = (sx(cfg_i.center_x) <<< 1) - ext_t'(cfg_i.box_width);
    maxx = (sx(cfg_i.center_x) <<< 1) + ext_t'(cfg_i.box_width);
    minz = (sx(cfg_i.center_z) <<< 1) - ext_t'(cfg_i.box_depth);
    maxz = (sx(cfg_i.center_z) <<< 1) + ext_t'(cfg_i.box_depth);
    r2e  = ext_t'({in_item_i.radius, 1'b0});
    clx  = (px2 < minx) ? minx : ((px2 > maxx) ? maxx : px2);
    clz  = (pz2 < minz) ? minz : ((pz2 > maxz) ? maxz : pz2);
    dxw  = px2 - clx;
    dzw  = pz2 - clz;
    f1_d.near = (dxw < FarLim) && (dxw > -FarLim) && (dzw < FarLim) && (dzw > -FarLim);
    f1_d.dx   = dxw[OffWidth-1:0];
    f1_d.dz   = dzw[OffWidth-1:0];
    f1_d.px   = in_item_i.pos_x;
    f1_d.pz   = in_item_i.pos_z;
    f1_d.r2   = {in_item_i.radius, 1'b0};
    f1_d.fl   = minx - r2e;
    f1_d.fr   = maxx + r2e;
    f1_d.fb   = minz - r2e;
    f1_d.ff   = maxz + r2e;
    f1_d.pl   = absv(px2 - f1_d.fl);
    f1_d.pr   = absv(f1_d.fr - px2);
    f1_d.pb   = absv(pz2 - f1_d.fb);
    f1_d.pf   = absv(f1_d.ff - pz2);
  end

  // stage 2: squared distance and nearest grown face (ties left, right, back, front)
  always_comb begin
    logic signed [SqWidth-1:0] sqx, sqz;
    logic sel_l, sel_r, sel_b;
    sqx   = f1_q.dx * f1_q.dx;
    sqz   = f1_q.dz * f1_q.dz;
    sel_l = (f1_q.pl <= f1_q.pr) && (f1_q.pl <= f1_q.pb) && (f1_q.pl <= f1_q.pf);
    sel_r = !sel_l && (f1_q.pr <= f1_q.pb) && (f1_q.pr <= f1_q.pf);
    sel_b = !sel_l && !sel_r && (f1_q.pb <= f1_q.pf);
    f2_d.near = f1_q.near;
    f2_d.dsq  = $unsigned(sqx) + $unsigned(sqz);
    f2_d.rsq  = DsqWidth'(f1_q.r2) * DsqWidth'(f1_q.r2);
    f2_d.dx   = f1_q.dx;
    f2_d.dz   = f1_q.dz;
    f2_d.px   = f1_q.px;
    f2_d.pz   = f1_q.pz;
    f2_d.r2   = f1_q.r2;
    f2_d.snap_x = f1_q.px;
    f2_d.snap_z = f1_q.pz;
    if (sel_l) f2_d.snap_x = sat_coord(wide_t'(f1_q.fl >>> 1));
    else if (sel_r) f2_d.snap_x = sat_coord(wide_t'((f1_q.fr + ext_t'(1)) >>> 1));
    else if (sel_b) f2_d.snap_z = sat_coord(wide_t'(f1_q.fb >>> 1));
    else f2_d.snap_z = sat_coord(wide_t'((f1_q.ff + ext_t'(1)) >>> 1));
  end

  // classify: miss, snap to face, or push along the offset
  always_comb begin
    logic hit;
    hit = f2_q.near && (f2_q.dsq < SqWidth'(f2_q.rsq));
    out_item_o.hit    = hit;
    out_item_o.push   = hit && (f2_q.dsq != '0);
    out_item_o.base_x = (hit && f2_q.dsq == '0) ? f2_q.snap_x : f2_q.px;
    out_item_o.base_z = (hit && f2_q.dsq == '0) ? f2_q.snap_z : f2_q.pz;
    out_item_o.dx     = f2_q.dx;
    out_item_o.dz     = f2_q.dz;
    out_item_o.dsq    = f2_q.dsq[DsqWidth-1:0];
    out_item_o.r2     = f2_q.r2;
  end

  assign out_valid_o = f2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (en_i) begin
      f1_v_q <= in_valid_i;
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q <= f1_d;
      f2_q <= f2_d;
    end
  end

endmodule

// ----- rtl/cbp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_back: push-out arithmetic pipeline
// Bit-per-stage square root, overlap, products, bit-per-stage dividers, saturate.
// ----------------------------------------------------------------------------
module cbp_back import cbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      in_valid_i,
  input  mid_item_t in_item_i,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  typedef struct packed {
    mid_item_t               it;
    logic [RadWidth-1:0]     rad;
    logic [RootWidth+1:0]    rem;
    logic [RootWidth-1:0]    root;
  } sq_t;

  typedef struct packed {
    mid_item_t               it;
    logic [RootWidth-1:0]    dlen;
    logic [OvlWidth-1:0]     ovl;
  } ov_t;

  typedef struct packed {
    mid_item_t               it;
    logic [RootWidth-1:0]    dlen;
    logic [MagWidth-1:0]     magx, magz;
    logic                    negx, negz;
  } mu_t;

  typedef struct packed {
    mid_item_t               it;
    logic [DenWidth-1:0]     den;
    logic [NumWidth-1:0]     remx, remz;
    logic [QuoWidth-1:0]     qx, qz;
    logic                    negx, negz;
  } dv_t;

  sq_t       sq_q   [RootWidth];
  logic      sq_v_q [RootWidth];
  sq_t       sq_init;
  ov_t       ov_d, ov_q;
  logic      ov_v_q;
  mu_t       mu_d, mu_q;
  logic      mu_v_q;
  dv_t       dv_init;
  dv_t       dv_q   [QuoWidth];
  logic      dv_v_q [QuoWidth];
  out_item_t res_d, res_q;
  logic      res_v_q;

  always_comb begin
    sq_init      = '0;
    sq_init.it   = in_item_i;
    sq_init.rad  = {in_item_i.dsq, {(RadWidth-DsqWidth){1'b0}}};
  end

  // square root: two radicand bits per stage
  for (genvar k = 0; k < RootWidth; k++) begin : g_sqrt
    sq_t                  src, nxt;
    logic                 src_v;
    logic [RootWidth+3:0] cur, trial;
    if (k == 0) begin : g_first
      assign src   = sq_init;
      assign src_v = in_valid_i;
    end else begin : g_next
      assign src   = sq_q[k-1];
      assign src_v = sq_v_q[k-1];
    end
    always_comb begin
      cur   = {src.rem, src.rad[RadWidth-1 -: 2]};
      trial = {2'b00, src.root, 2'b01};
      nxt     = src;
      nxt.rad = src.rad << 2;
      if (cur >= trial) begin
        nxt.rem  = (RootWidth+2)'(cur - trial);
        nxt.root = {src.root[RootWidth-2:0], 1'b1};
      end else begin
        nxt.rem  = cur[RootWidth+1:0];
        nxt.root = {src.root[RootWidth-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k] <= 1'b0;
      else if (en_i) sq_v_q[k] <= src_v;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) sq_q[k] <= nxt;
    end
  end

  // overlap = 2r * 4096 - distance
  always_comb begin
    ov_d.it   = sq_q[RootWidth-1].it;
    ov_d.dlen = sq_q[RootWidth-1].root;
    ov_d.ovl  = {sq_q[RootWidth-1].it.r2, 12'b0} - sq_q[RootWidth-1].root;
  end

  always_comb begin
    logic signed [ProdWidth-1:0] px, pz;
    px = ov_q.it.dx * $signed({1'b0, ov_q.ovl});
    pz = ov_q.it.dz * $signed({1'b0, ov_q.ovl});
    mu_d.it   = ov_q.it;
    mu_d.dlen = ov_q.dlen;
    mu_d.negx = px[ProdWidth-1];
    mu_d.negz = pz[ProdWidth-1];
    mu_d.magx = px[ProdWidth-1] ? MagWidth'(-px) : px[MagWidth-1:0];
    mu_d.magz = pz[ProdWidth-1] ? MagWidth'(-pz) : pz[MagWidth-1:0];
  end

  // round to nearest: add half the divisor (= distance) before dividing by twice it
  always_comb begin
    dv_init      = '0;
    dv_init.it   = mu_q.it;
    dv_init.den  = {mu_q.dlen, 1'b0};
    dv_init.remx = NumWidth'(mu_q.magx) + NumWidth'(mu_q.dlen);
    dv_init.remz = NumWidth'(mu_q.magz) + NumWidth'(mu_q.dlen);
    dv_init.negx = mu_q.negx;
    dv_init.negz = mu_q.negz;
  end

  // restoring division: one quotient bit per stage, most significant first
  for (genvar j = 0; j < QuoWidth; j++) begin : g_div
    localparam int Bit = QuoWidth - 1 - j;
    dv_t                 src, nxt;
    logic                src_v;
    logic [NumWidth-1:0] sub;
    if (j == 0) begin : g_first
      assign src   = dv_init;
      assign src_v = mu_v_q;
    end else begin : g_next
      assign src   = dv_q[j-1];
      assign src_v = dv_v_q[j-1];
    end
    always_comb begin
      sub = NumWidth'(src.den) << Bit;
      nxt = src;
      if (src.remx >= sub) begin
        nxt.remx    = src.remx - sub;
        nxt.qx[Bit] = 1'b1;
      end
      if (src.remz >= sub) begin
        nxt.remz    = src.remz - sub;
        nxt.qz[Bit] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[j] <= 1'b0;
      else if (en_i) dv_v_q[j] <= src_v;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) dv_q[j] <= nxt;
    end
  end

  always_comb begin
    dv_t   last;
    wide_t stepx, stepz;
    last  = dv_q[QuoWidth-1];
    stepx = last.negx ? -wide_t'(last.qx) : wide_t'(last.qx);
    stepz = last.negz ? -wide_t'(last.qz) : wide_t'(last.qz);
    res_d.hit   = last.it.hit;
    res_d.new_x = last.it.base_x;
    res_d.new_z = last.it.base_z;
    if (last.it.push) begin
      res_d.new_x = sat_coord(wide_t'(last.it.base_x) + stepx);
      res_d.new_z = sat_coord(wide_t'(last.it.base_z) + stepz);
    end
  end

  assign out_valid_o = res_v_q;
  assign out_item_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_v_q  <= 1'b0;
      mu_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else if (en_i) begin
      ov_v_q  <= sq_v_q[RootWidth-1];
      mu_v_q  <= ov_v_q;
      res_v_q <= dv_v_q[QuoWidth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ov_q  <= ov_d;
      mu_q  <= mu_d;
      res_q <= res_d;
    end
  end

endmodule

// ----- rtl/circle_box_pushout.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_box_pushout: circle versus axis-aligned box resolution in x-z
// Push-out or face snap of a circle against a configured box, one test a cycle while full is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive in_item_i and raise push; a beat is taken on an
//   edge with push high and full low. Result side: while empty is low the
//   oldest result sits on out_item_o; raise pop to take it.
//   Configuration: cfg_valid_i with cfg_index_i/cfg_data_i, always ready.
//   Write only while no tests are in flight.
// Timing:
//   One beat per cycle sustained while full stays low. A taken beat passes
//   through two front stages, the classified-item queue, 29 square root
//   stages, overlap and product stages, 18 divider stages, the result
//   register and the output queue, in that order.
// Reset:
//   Clears the box registers to zero and empties every queue and stage.
// Stall:
//   With pop low the back pipeline holds once the output queue is full; the
//   classified-item queue then fills and full rises to hold off the sender.
// ----------------------------------------------------------------------------
module circle_box_pushout import cbp_pkg::*; #(
  parameter int MID_DEPTH = MidDepth,
  parameter int OUT_DEPTH = OutDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  in_item_t               in_item_i,
  output logic                   empty,
  input  logic                   pop,
  output out_item_t              out_item_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CoordWidth-1:0]  cfg_data_i
);

  box_cfg_t  cfg_q;
  logic      mid_wr_valid, mid_wr_ready, mid_rd_valid;
  mid_item_t mid_wr_item, mid_rd_item;
  logic      back_en, out_wr_valid, out_wr_ready, out_rd_valid;
  out_item_t out_wr_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgCenterX:  cfg_q.center_x  <= cfg_data_i;
        CfgCenterZ:  cfg_q.center_z  <= cfg_data_i;
        CfgBoxWidth: cfg_q.box_width <= cfg_data_i[SpanWidth-1:0];
        CfgBoxDepth: cfg_q.box_depth <= cfg_data_i[SpanWidth-1:0];
        default: ;
      endcase
    end
  end

  assign full = !mid_wr_ready;

  cbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (mid_wr_ready),
    .in_valid_i  (push),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg_q),
    .out_valid_o (mid_wr_valid),
    .out_item_o  (mid_wr_item)
  );

  cbp_queue #(.DEPTH(MID_DEPTH), .item_t(mid_item_t)) u_mid_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (mid_wr_valid),
    .wr_ready_o (mid_wr_ready),
    .wr_item_i  (mid_wr_item),
    .rd_valid_o (mid_rd_valid),
    .rd_ready_i (back_en),
    .rd_item_o  (mid_rd_item)
  );

  // advance the back pipeline only while the output queue has room
  assign back_en = out_wr_ready;

  cbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (back_en),
    .in_valid_i  (mid_rd_valid),
    .in_item_i   (mid_rd_item),
    .out_valid_o (out_wr_valid),
    .out_item_o  (out_wr_item)
  );

  cbp_queue #(.DEPTH(OUT_DEPTH), .item_t(out_item_t)) u_out_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (out_wr_valid),
    .wr_ready_o (out_wr_ready),
    .wr_item_i  (out_wr_item),
    .rd_valid_o (out_rd_valid),
    .rd_ready_i (pop),
    .rd_item_o  (out_item_o)
  );

  assign empty = !out_rd_valid;

`ifndef SYNTHESIS
  a_back_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_wr_valid && !out_wr_ready |=> out_wr_valid && $stable(out_wr_item))
    else $error("back pipeline dropped or changed a stalled result");

  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_wr_valid && !mid_wr_ready |=> mid_wr_valid && $stable(mid_wr_item))
    else $error("front dropped or changed a stalled item");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> mid_rd_valid)
    else $error("input held off with an empty classified-item queue");
`endif

endmodule

// ----- tb/circle_box_pushout_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_box_pushout_test: self-checking bench for the circle/box push-out
// Drives circle tests under several box settings, predicts each resolved
// position in the bench and compares every result beat field by field.
// ----------------------------------------------------------------------------
module circle_box_pushout_test;
  import cbp_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 120;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  in_item_t               in_item_i;
  logic                   empty;
  logic                   pop;
  out_item_t              out_item_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [CoordWidth-1:0]  cfg_data_i;

  out_item_t resolved_q[$];
  box_cfg_t  box;
  int        mismatches;
  int        push_idle_pct;
  int        pop_idle_pct;
  int        hold_pop;
  int        idle_cycles;
  bit        timed_out;

  circle_box_pushout i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---- prediction ----
  function automatic longint clamp_l(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat_l(longint v);
    longint hi;
    hi = (64'sd1 <<< (CoordWidth - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint floor_half_l(longint v);
    return (v - (v & 1)) / 2;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic out_item_t resolve_circle(in_item_t it, box_cfg_t bx);
    out_item_t o;
    longint px, pz, r2, minx, maxx, minz, maxz, dx, dz, nx, nz;
    longint dlen, ovl, fl, fr, fb, ff, pl, pr, pb, pf, m;
    longint unsigned dsq;
    bit hit;
    px = it.pos_x;
    pz = it.pos_z;
    r2 = 2 * longint'(it.radius);
    minx = 2 * longint'(bx.center_x) - longint'(bx.box_width);
    maxx = 2 * longint'(bx.center_x) + longint'(bx.box_width);
    minz = 2 * longint'(bx.center_z) - longint'(bx.box_depth);
    maxz = 2 * longint'(bx.center_z) + longint'(bx.box_depth);
    dx = 2 * px - clamp_l(2 * px, minx, maxx);
    dz = 2 * pz - clamp_l(2 * pz, minz, maxz);
    nx = px;
    nz = pz;
    hit = 1'b0;
    if (abs_l(dx) < (64'sd1 <<< 18) && abs_l(dz) < (64'sd1 <<< 18)) begin
      dsq = dx * dx + dz * dz;
      if (dsq < r2 * r2) begin
        hit = 1'b1;
        if (dsq != 0) begin
          dlen = root_floor(dsq << 24);
          ovl = (r2 <<< 12) - dlen;
          nx = sat_l(px + round_div(dx * ovl, 2 * dlen));
          nz = sat_l(pz + round_div(dz * ovl, 2 * dlen));
        end else begin
          fl = minx - r2;
          fr = maxx + r2;
          fb = minz - r2;
          ff = maxz + r2;
          pl = abs_l(2 * px - fl);
          pr = abs_l(fr - 2 * px);
          pb = abs_l(2 * pz - fb);
          pf = abs_l(ff - 2 * pz);
          m = pl;
          if (pr < m) m = pr;
          if (pb < m) m = pb;
          if (pf < m) m = pf;
          if (m == pl) nx = sat_l(floor_half_l(fl));
          else if (m == pr) nx = sat_l(-floor_half_l(-fr));
          else if (m == pb) nz = sat_l(floor_half_l(fb));
          else nz = sat_l(-floor_half_l(-ff));
        end
      end
    end
    o.hit = hit;
    o.new_x = nx[CoordWidth-1:0];
    o.new_z = nz[CoordWidth-1:0];
    return o;
  endfunction

  // ---- drivers ----
  task automatic write_box_reg(cfg_idx_e idx, logic [CoordWidth-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgCenterX:  box.center_x = val;
      CfgCenterZ:  box.center_z = val;
      CfgBoxWidth: box.box_width = val[SpanWidth-1:0];
      CfgBoxDepth: box.box_depth = val[SpanWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic set_box(logic [CoordWidth-1:0] cx, logic [CoordWidth-1:0] cz,
                         logic [SpanWidth-1:0] w, logic [SpanWidth-1:0] d);
    push <= 1'b0;
    // drain before touching the box registers
    while (resolved_q.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    write_box_reg(CfgCenterX, cx);
    write_box_reg(CfgCenterZ, cz);
    write_box_reg(CfgBoxWidth, {1'b0, w});
    write_box_reg(CfgBoxDepth, {1'b0, d});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_circle(logic [CoordWidth-1:0] x, logic [CoordWidth-1:0] z,
                             logic [RadiusWidth-1:0] r);
    in_item_t it;
    it.pos_x = x;
    it.pos_z = z;
    it.radius = r;
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    resolved_q.push_back(resolve_circle(it, box));
  endtask

  // ---- checking ----
  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        idle_cycles <= 0;
        if (resolved_q.size() == 0) begin
          report_mismatch("unexpected beat", out_item_o.new_x, 0);
        end else begin
          want = resolved_q.pop_front();
          if (out_item_o.hit !== want.hit) report_mismatch("hit", out_item_o.hit, want.hit);
          if (out_item_o.new_x !== want.new_x)
            report_mismatch("new_x", out_item_o.new_x, want.new_x);
          if (out_item_o.new_z !== want.new_z)
            report_mismatch("new_z", out_item_o.new_z, want.new_z);
        end
      end else if (push && !full) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (hold_pop > 0) begin
        hold_pop <= hold_pop - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---- tests ----
  function automatic logic [CoordWidth-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CoordWidth'($urandom());
      1: return CoordWidth'($urandom_range(4095) - 2048);
      default: return CoordWidth'($urandom_range(16'hffff) - 16'h8000);
    endcase
  endfunction

  task automatic test_directed();
    set_box(24'sd0, 24'sd0, 23'd2048, 23'd1024);
    send_circle(24'h7fffff, 24'h7fffff, 16'hffff);
    send_circle(24'h800000, 24'h800000, 16'hffff);
    send_circle(24'd0, 24'd0, 16'd0);              // zero radius never hits
    send_circle(24'd0, 24'd0, 16'd256);            // inside, nearest face back
    send_circle(24'd1200, 24'd0, 16'd100);         // outside, no overlap
    send_circle(24'd1050, 24'd0, 16'd100);         // push along x
    send_circle(24'd1050, 24'd520, 16'd256);       // push along a corner
    send_circle(-24'sd1024, 24'd0, 16'd10);        // on left face: snap
    send_circle(24'd1024, 24'd0, 16'd10);
    send_circle(24'd0, -24'sd512, 16'd10);
    send_circle(24'd0, 24'd512, 16'd10);
    send_circle(24'd0, 24'd300000, 16'hffff);      // far offset rejected
    set_box(24'h7fff00, 24'h800100, 23'h7fffff, 23'h7fffff);
    send_circle(24'h7fffff, 24'h000000, 16'hffff); // far z offset rejected
    send_circle(24'd1, 24'd1, 16'h8000);
    set_box(24'd0, 24'd0, 23'd3, 23'd3);           // odd spans: half-LSB faces
    send_circle(24'd0, 24'd0, 16'd1);
    send_circle(24'd0, 24'd0, 16'd300);
    send_circle(24'd1, 24'd0, 16'd300);
  endtask

  task automatic test_random(int n, int cmax);
    logic [CoordWidth-1:0] cx, cz;
    logic [SpanWidth-1:0]  w, d;
    cx = $urandom_range(1) ? CoordWidth'($urandom())
                           : CoordWidth'($urandom_range(cmax) - cmax / 2);
    cz = $urandom_range(1) ? CoordWidth'($urandom())
                           : CoordWidth'($urandom_range(cmax) - cmax / 2);
    w = $urandom_range(7) == 0 ? SpanWidth'($urandom()) : SpanWidth'($urandom_range(cmax));
    d = $urandom_range(7) == 0 ? SpanWidth'($urandom()) : SpanWidth'($urandom_range(cmax));
    set_box(cx, cz, w, d);
    repeat (n) begin
      // aim most circles near the box
      if ($urandom_range(9) < 8)
        send_circle(CoordWidth'($signed(cx) + $signed(rand_coord()) / 4),
                    CoordWidth'($signed(cz) + $signed(rand_coord()) / 4),
                    $urandom_range(3) == 0 ? RadiusWidth'($urandom())
                                           : RadiusWidth'($urandom_range(4095)));
      else
        send_circle(CoordWidth'($urandom()), CoordWidth'($urandom()),
                    RadiusWidth'($urandom()));
    end
  endtask

  task automatic test_backpressure();
    hold_pop = 400;
    repeat (120) send_circle(rand_coord(), rand_coord(), RadiusWidth'($urandom_range(2047)));
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgCenterX;
    cfg_data_i = '0;
    box = '0;
    mismatches = 0;
    hold_pop = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    push_idle_pct = 0;
    pop_idle_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    push_idle_pct = 6;
    pop_idle_pct = 63;
    repeat (3) test_random(175, 4096);
    push_idle_pct = 63;
    pop_idle_pct = 6;
    repeat (3) test_random(175, 65536);
    push_idle_pct = 0;
    pop_idle_pct = 0;
    repeat (3) test_random(175, 1024);
    test_backpressure();
    set_box(24'h800000, 24'h7fffff, 23'd0, 23'h7fffff);
    repeat (40) send_circle(CoordWidth'($urandom()), CoordWidth'($urandom()),
                            RadiusWidth'($urandom()));
    push <= 1'b0;
    while (resolved_q.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
